/* hdl/gfti_pkg.sv */
// Shared types, constants and the Gaussian coefficient tables of the four-tap interpolator.
package gfti_pkg;

  localparam int TAIL_SLOTS          = 3;
  localparam int BLOCK_SAMPLES_DEF   = 28;
  localparam int OUTPUT_SHIFT        = 15;
  localparam int TABLE_ENTRIES       = 512;
  localparam int HALF_ENTRIES        = TABLE_ENTRIES / 2;
  localparam int NUM_TAPS            = 4;
  localparam int SUM_WIDTH           = 34;
  localparam int RESULT_WIDTH        = 17;

  localparam logic REQ_WRITE       = 1'b0;
  localparam logic REQ_INTERPOLATE = 1'b1;

  typedef logic signed [15:0] sample_t;
  typedef sample_t [NUM_TAPS-1:0] sample_quad_t;
  typedef logic signed [31:0] product_t;

  typedef struct packed {
    logic        req_type;
    logic [4:0]  sample_slot;
    sample_t     sample_value;
    logic [16:0] pitch_counter;
  } gfti_item_t;

  typedef struct packed {
    logic signed [RESULT_WIDTH-1:0] interpolated;
    logic                           position_error;
  } gfti_result_t;

  typedef struct packed {
    logic       en;
    logic [4:0] slot;
    sample_t    value;
  } store_wr_t;

  // Tap that a bank serves when the window starts at a position whose low bits are plow.
  function automatic logic [1:0] bank_tap(input logic [1:0] bank, input logic [1:0] plow);
    bank_tap = bank - plow;
  endfunction

  // Lower half of the table: entries 0 to 255.
  localparam sample_t GAUSS_LO [HALF_ENTRIES] = '{
    16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
    16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
    16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0001,
    16'h0001, 16'h0001, 16'h0001, 16'h0002, 16'h0002, 16'h0002, 16'h0003, 16'h0003,
    16'h0003, 16'h0004, 16'h0004, 16'h0005, 16'h0005, 16'h0006, 16'h0007, 16'h0007,
    16'h0008, 16'h0009, 16'h0009, 16'h000A, 16'h000B, 16'h000C, 16'h000D, 16'h000E,
    16'h000F, 16'h0010, 16'h0011, 16'h0012, 16'h0013, 16'h0015, 16'h0016, 16'h0018,
    16'h0019, 16'h001B, 16'h001C, 16'h001E, 16'h0020, 16'h0021, 16'h0023, 16'h0025,
    16'h0027, 16'h0029, 16'h002C, 16'h002E, 16'h0030, 16'h0033, 16'h0035, 16'h0038,
    16'h003A, 16'h003D, 16'h0040, 16'h0043, 16'h0046, 16'h0049, 16'h004D, 16'h0050,
    16'h0054, 16'h0057, 16'h005B, 16'h005F, 16'h0063, 16'h0067, 16'h006B, 16'h006F,
    16'h0074, 16'h0078, 16'h007D, 16'h0082, 16'h0087, 16'h008C, 16'h0091, 16'h0096,
    16'h009C, 16'h00A1, 16'h00A7, 16'h00AD, 16'h00B3, 16'h00BA, 16'h00C0, 16'h00C7,
    16'h00CD, 16'h00D4, 16'h00DB, 16'h00E3, 16'h00EA, 16'h00F2, 16'h00FA, 16'h0101,
    16'h010A, 16'h0112, 16'h011B, 16'h0123, 16'h012C, 16'h0135, 16'h013F, 16'h0148,
    16'h0152, 16'h015C, 16'h0166, 16'h0171, 16'h017B, 16'h0186, 16'h0191, 16'h019C,
    16'h01A8, 16'h01B4, 16'h01C0, 16'h01CC, 16'h01D9, 16'h01E5, 16'h01F2, 16'h0200,
    16'h020D, 16'h021B, 16'h0229, 16'h0237, 16'h0246, 16'h0255, 16'h0264, 16'h0273,
    16'h0283, 16'h0293, 16'h02A3, 16'h02B4, 16'h02C4, 16'h02D6, 16'h02E7, 16'h02F9,
    16'h030B, 16'h031D, 16'h0330, 16'h0343, 16'h0356, 16'h036A, 16'h037E, 16'h0392,
    16'h03A7, 16'h03BC, 16'h03D1, 16'h03E7, 16'h03FC, 16'h0413, 16'h042A, 16'h0441,
    16'h0458, 16'h0470, 16'h0488, 16'h04A0, 16'h04B9, 16'h04D2, 16'h04EC, 16'h0506,
    16'h0520, 16'h053B, 16'h0556, 16'h0572, 16'h058E, 16'h05AA, 16'h05C7, 16'h05E4,
    16'h0601, 16'h061F, 16'h063E, 16'h065C, 16'h067C, 16'h069B, 16'h06BB, 16'h06DC,
    16'h06FD, 16'h071E, 16'h0740, 16'h0762, 16'h0784, 16'h07A7, 16'h07CB, 16'h07EF,
    16'h0813, 16'h0838, 16'h085D, 16'h0883, 16'h08A9, 16'h08D0, 16'h08F7, 16'h091E,
    16'h0946, 16'h096F, 16'h0998, 16'h09C1, 16'h09EB, 16'h0A16, 16'h0A40, 16'h0A6C,
    16'h0A98, 16'h0AC4, 16'h0AF1, 16'h0B1E, 16'h0B4C, 16'h0B7A, 16'h0BA9, 16'h0BD8,
    16'h0C07, 16'h0C38, 16'h0C68, 16'h0C99, 16'h0CCB, 16'h0CFD, 16'h0D30, 16'h0D63,
    16'h0D97, 16'h0DCB, 16'h0E00, 16'h0E35, 16'h0E6B, 16'h0EA1, 16'h0ED7, 16'h0F0F,
    16'h0F46, 16'h0F7F, 16'h0FB7, 16'h0FF1, 16'h102A, 16'h1065, 16'h109F, 16'h10DB,
    16'h1116, 16'h1153, 16'h118F, 16'h11CD, 16'h120B, 16'h1249, 16'h1288, 16'h12C7
  };

  // Upper half of the table: entries 256 to 511.
  localparam sample_t GAUSS_HI [HALF_ENTRIES] = '{
    16'h1307, 16'h1347, 16'h1388, 16'h13C9, 16'h140B, 16'h144D, 16'h1490, 16'h14D4,
    16'h1517, 16'h155C, 16'h15A0, 16'h15E6, 16'h162C, 16'h1672, 16'h16B9, 16'h1700,
    16'h1747, 16'h1790, 16'h17D8, 16'h1821, 16'h186B, 16'h18B5, 16'h1900, 16'h194B,
    16'h1996, 16'h19E2, 16'h1A2E, 16'h1A7B, 16'h1AC8, 16'h1B16, 16'h1B64, 16'h1BB3,
    16'h1C02, 16'h1C51, 16'h1CA1, 16'h1CF1, 16'h1D42, 16'h1D93, 16'h1DE5, 16'h1E37,
    16'h1E89, 16'h1EDC, 16'h1F2F, 16'h1F82, 16'h1FD6, 16'h202A, 16'h207F, 16'h20D4,
    16'h2129, 16'h217F, 16'h21D5, 16'h222C, 16'h2282, 16'h22DA, 16'h2331, 16'h2389,
    16'h23E1, 16'h2439, 16'h2492, 16'h24EB, 16'h2545, 16'h259E, 16'h25F8, 16'h2653,
    16'h26AD, 16'h2708, 16'h2763, 16'h27BE, 16'h281A, 16'h2876, 16'h28D2, 16'h292E,
    16'h298B, 16'h29E7, 16'h2A44, 16'h2AA1, 16'h2AFF, 16'h2B5C, 16'h2BBA, 16'h2C18,
    16'h2C76, 16'h2CD4, 16'h2D33, 16'h2D91, 16'h2DF0, 16'h2E4F, 16'h2EAE, 16'h2F0D,
    16'h2F6C, 16'h2FCC, 16'h302B, 16'h308B, 16'h30EA, 16'h314A, 16'h31AA, 16'h3209,
    16'h3269, 16'h32C9, 16'h3329, 16'h3389, 16'h33E9, 16'h3449, 16'h34A9, 16'h3509,
    16'h3569, 16'h35C9, 16'h3629, 16'h3689, 16'h36E8, 16'h3748, 16'h37A8, 16'h3807,
    16'h3867, 16'h38C6, 16'h3926, 16'h3985, 16'h39E4, 16'h3A43, 16'h3AA2, 16'h3B00,
    16'h3B5F, 16'h3BBD, 16'h3C1B, 16'h3C79, 16'h3CD7, 16'h3D35, 16'h3D92, 16'h3DEF,
    16'h3E4C, 16'h3EA9, 16'h3F05, 16'h3F62, 16'h3FBD, 16'h4019, 16'h4074, 16'h40D0,
    16'h412A, 16'h4185, 16'h41DF, 16'h4239, 16'h4292, 16'h42EB, 16'h4344, 16'h439C,
    16'h43F4, 16'h444C, 16'h44A3, 16'h44FA, 16'h4550, 16'h45A6, 16'h45FC, 16'h4651,
    16'h46A6, 16'h46FA, 16'h474E, 16'h47A1, 16'h47F4, 16'h4846, 16'h4898, 16'h48E9,
    16'h493A, 16'h498A, 16'h49D9, 16'h4A29, 16'h4A77, 16'h4AC5, 16'h4B13, 16'h4B5F,
    16'h4BAC, 16'h4BF7, 16'h4C42, 16'h4C8D, 16'h4CD7, 16'h4D20, 16'h4D68, 16'h4DB0,
    16'h4DF7, 16'h4E3E, 16'h4E84, 16'h4EC9, 16'h4F0E, 16'h4F52, 16'h4F95, 16'h4FD7,
    16'h5019, 16'h505A, 16'h509A, 16'h50DA, 16'h5118, 16'h5156, 16'h5194, 16'h51D0,
    16'h520C, 16'h5247, 16'h5281, 16'h52BA, 16'h52F3, 16'h532A, 16'h5361, 16'h5397,
    16'h53CC, 16'h5401, 16'h5434, 16'h5467, 16'h5499, 16'h54CA, 16'h54FA, 16'h5529,
    16'h5558, 16'h5585, 16'h55B2, 16'h55DE, 16'h5609, 16'h5632, 16'h565B, 16'h5684,
    16'h56AB, 16'h56D1, 16'h56F6, 16'h571B, 16'h573E, 16'h5761, 16'h5782, 16'h57A3,
    16'h57C3, 16'h57E2, 16'h57FF, 16'h581C, 16'h5838, 16'h5853, 16'h586D, 16'h5886,
    16'h589E, 16'h58B5, 16'h58CB, 16'h58E0, 16'h58F4, 16'h5907, 16'h5919, 16'h592A,
    16'h593A, 16'h5949, 16'h5958, 16'h5965, 16'h5971, 16'h597C, 16'h5986, 16'h598F,
    16'h5997, 16'h599E, 16'h59A4, 16'h59A9, 16'h59AD, 16'h59B0, 16'h59B2, 16'h59B3
  };

endpackage

/* hdl/gaussian_four_tap_interpolator.sv */
// Four-tap Gaussian sample interpolator: one item accepted per cycle unless the result side stalls.
//
// Each beat on the item channel is either a sample write or an interpolation
// request; only requests produce a beat on the result channel. The datapath is
// a three-stage pipeline (bank read and coefficient lookup, four parallel
// 16x16 multiplies, adder tree with the shift), so one item enters per clock
// unless stalled, and its result leaves the third stage register. The whole pipeline
// halts while a result waits under stall, and item_stall is raised for those
// cycles. A write takes effect at its own beat, so a request right behind it
// already sees the new sample. There is no clearing pass after reset; a slot
// must be written before any request reads it.
module gaussian_four_tap_interpolator
  import gfti_pkg::*;
#(
  parameter int BLOCK_SAMPLES = BLOCK_SAMPLES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  output logic         item_stall,
  input  gfti_item_t   item,
  output logic         result_valid,
  input  logic         result_stall,
  output gfti_result_t result
);

  logic         advance;
  logic         item_take;
  store_wr_t    store_wr;
  logic [7:0]   phase;
  logic [4:0]   pos;
  sample_t      tap_coef [NUM_TAPS];
  sample_quad_t coef_sel;
  sample_quad_t samples;

  logic         a_valid;
  logic         a_err;
  sample_quad_t coef_a;
  logic         b_valid;
  logic         b_err;
  product_t     prod [NUM_TAPS];
  logic signed [SUM_WIDTH-1:0] acc;

  assign advance    = !(result_valid && result_stall);
  assign item_stall = !advance;
  assign item_take  = item_valid && advance;

  assign phase = item.pitch_counter[11:4];
  assign pos   = item.pitch_counter[16:12];

  assign store_wr.en    = item_take && (item.req_type == REQ_WRITE);
  assign store_wr.slot  = item.sample_slot;
  assign store_wr.value = item.sample_value;

  gfti_sample_store #(
    .BLOCK_SAMPLES(BLOCK_SAMPLES)
  ) u_store (
    .clk    (clk),
    .wr     (store_wr),
    .rd_en  (item_take),
    .rd_pos (pos),
    .rd_data(samples)
  );

  // Oldest tap uses 255-g, then 511-g, 256+g, and the newest uses g.
  always_comb begin
    tap_coef[0] = GAUSS_LO[~phase];
    tap_coef[1] = GAUSS_HI[~phase];
    tap_coef[2] = GAUSS_HI[phase];
    tap_coef[3] = GAUSS_LO[phase];
    for (int b = 0; b < NUM_TAPS; b++) begin
      coef_sel[b] = tap_coef[bank_tap(2'(b), pos[1:0])];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (advance) begin
      a_valid <= item_take && (item.req_type == REQ_INTERPOLATE);
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      a_err  <= 6'(pos) >= 6'(BLOCK_SAMPLES);
      coef_a <= coef_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (advance) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      b_err <= a_err;
      for (int b = 0; b < NUM_TAPS; b++) begin
        prod[b] <= samples[b] * coef_a[b];
      end
    end
  end

  assign acc = SUM_WIDTH'(prod[0]) + SUM_WIDTH'(prod[1])
             + SUM_WIDTH'(prod[2]) + SUM_WIDTH'(prod[3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= b_valid;
    end
  end

  // Taking the bits above the shift floors toward minus infinity.
  always_ff @(posedge clk) begin
    if (advance) begin
      result.position_error <= b_err;
      result.interpolated   <= b_err ? '0 : acc[OUTPUT_SHIFT +: RESULT_WIDTH];
    end
  end

endmodule

/* hdl/gfti_sample_store.sv */
// Sample store split into four banks by slot modulo four, with registered read data.
module gfti_sample_store
  import gfti_pkg::*;
#(
  parameter int BLOCK_SAMPLES = BLOCK_SAMPLES_DEF
) (
  input  logic         clk,
  input  store_wr_t    wr,
  input  logic         rd_en,
  input  logic [4:0]   rd_pos,
  output sample_quad_t rd_data
);

  localparam int STORE_SLOTS = TAIL_SLOTS + BLOCK_SAMPLES;
  localparam int BANK_DEPTH  = (STORE_SLOTS + NUM_TAPS - 1) / NUM_TAPS;
  localparam int AW          = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  logic          wr_ok;
  logic [AW-1:0] wr_addr;

  assign wr_ok   = wr.en && (6'(wr.slot) < 6'(STORE_SLOTS));
  assign wr_addr = AW'(wr.slot >> 2);

  // Four consecutive slots always fall into four different banks, so every
  // bank is read at exactly one address per item.
  for (genvar b = 0; b < NUM_TAPS; b++) begin : g_bank
    sample_t       mem [BANK_DEPTH];
    sample_t       rd_q;
    logic [5:0]    rd_slot;
    logic [AW-1:0] rd_addr;

    assign rd_slot = 6'(rd_pos) + 6'(bank_tap(2'(b), rd_pos[1:0]));
    assign rd_addr = AW'(rd_slot >> 2);

    always_ff @(posedge clk) begin
      if (wr_ok && (wr.slot[1:0] == 2'(b))) begin
        mem[wr_addr] <= wr.value;
      end
    end

    always_ff @(posedge clk) begin
      if (rd_en) begin
        rd_q <= mem[rd_addr];
      end
    end

    assign rd_data[b] = rd_q;
  end

endmodule

/* hdl/gfti_checker.sv */
// Port-level checker for the interpolator and its bind to the top level.
module gfti_checker
  import gfti_pkg::*;
(
  input logic         clk,
  input logic         rst,
  input logic         item_valid,
  input logic         item_stall,
  input gfti_item_t   item,
  input logic         result_valid,
  input logic         result_stall,
  input gfti_result_t result
);

  // A held result beat stays offered.
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result beat dropped while stalled");

  // The item side only stalls because a result is held.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid && result_stall)
    else $error("item channel stalled without a held result");

  // An out-of-range position always yields zero.
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.position_error |-> result.interpolated == '0)
    else $error("position error with nonzero result");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result beat right after reset");

  // A request seen by an idle block comes out as a result beat if the result side does not stall meanwhile.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && item.req_type == REQ_INTERPOLATE && !result_valid
    ##1 !result_stall ##1 !result_stall |=> result_valid)
    else $error("interpolation result missing after three cycles");

endmodule

bind gaussian_four_tap_interpolator gfti_checker u_gfti_checker (
  .clk         (clk),
  .rst         (rst),
  .item_valid  (item_valid),
  .item_stall  (item_stall),
  .item        (item),
  .result_valid(result_valid),
  .result_stall(result_stall),
  .result      (result)
);

/* sim/gaussian_four_tap_interpolator_test.sv */
// Self-checking testbench for the four-tap Gaussian interpolator: directed and streamed beats.
module gaussian_four_tap_interpolator_test
  import gfti_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_DEPTH = TAIL_SLOTS + BLOCK_SAMPLES_DEF;
  localparam int DRAIN_LIMIT = 20000;

  logic         clk;
  logic         rst = 1'b1;
  logic         item_valid = 1'b0;
  logic         item_stall;
  gfti_item_t   item = '0;
  logic         result_valid;
  logic         result_stall = 1'b0;
  gfti_result_t result;

  sample_t      shadow_store [STORE_DEPTH];
  gfti_result_t predicted_results [$];
  int           mismatch_count = 0;
  int           send_idle_pct = 33;
  int           sink_stall_pct = 33;

  gaussian_four_tap_interpolator u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic sample_t gauss_coef(input int idx);
    return (idx < HALF_ENTRIES) ? GAUSS_LO[idx] : GAUSS_HI[idx - HALF_ENTRIES];
  endfunction

  // Window x[p-3..p] lives in store slots p..p+3, since the three tail slots come first.
  function automatic gfti_result_t interpolate_expected(input logic [16:0] ctr);
    logic [7:0]   phase;
    logic [4:0]   pos;
    longint       acc;
    gfti_result_t r;
    phase = ctr[11:4];
    pos   = ctr[16:12];
    r = '0;
    if (pos > BLOCK_SAMPLES_DEF - 1) begin
      r.position_error = 1'b1;
    end else begin
      acc = longint'(gauss_coef(255 - phase)) * shadow_store[pos]
          + longint'(gauss_coef(511 - phase)) * shadow_store[pos + 1]
          + longint'(gauss_coef(256 + phase)) * shadow_store[pos + 2]
          + longint'(gauss_coef(phase))       * shadow_store[pos + 3];
      r.interpolated = RESULT_WIDTH'(acc >>> OUTPUT_SHIFT);
    end
    return r;
  endfunction

  function automatic sample_t random_sample();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) return 16'sh7FFF;
    if (pick < 20) return 16'sh8000;
    return sample_t'($urandom);
  endfunction

  function automatic gfti_item_t write_item(input logic [4:0] slot, input sample_t value);
    gfti_item_t it;
    it.req_type      = REQ_WRITE;
    it.sample_slot   = slot;
    it.sample_value  = value;
    it.pitch_counter = 17'($urandom);
    return it;
  endfunction

  function automatic gfti_item_t interp_item(input logic [16:0] ctr);
    gfti_item_t it;
    it.req_type      = REQ_INTERPOLATE;
    it.sample_slot   = 5'($urandom);
    it.sample_value  = sample_t'($urandom);
    it.pitch_counter = ctr;
    return it;
  endfunction

  function automatic logic [16:0] counter_at(input logic [4:0] pos, input logic [7:0] phase);
    return {pos, phase, 4'($urandom)};
  endfunction

  // Drives one beat and updates the prediction once the block has taken it.
  task automatic send_item(input gfti_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (item_stall);
    if (it.req_type == REQ_INTERPOLATE)
      predicted_results.push_back(interpolate_expected(it.pitch_counter));
    else if (it.sample_slot < STORE_DEPTH)
      shadow_store[it.sample_slot] = it.sample_value;
  endtask

  task automatic wait_results_drained();
    int waited;
    waited = 0;
    @(negedge clk);
    item_valid <= 1'b0;
    while (predicted_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
  endtask

  task automatic note_mismatch(input string what, input gfti_result_t want,
                               input gfti_result_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s: expected %0d error %0b, got %0d error %0b",
               $realtime, what, want.interpolated, want.position_error,
               got.interpolated, got.position_error);
  endtask

  always @(negedge clk) result_stall <= ($urandom_range(99) < sink_stall_pct);

  always @(posedge clk) begin : check_results
    gfti_result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (predicted_results.size() == 0) begin
        note_mismatch("result beat with nothing predicted", '0, result);
      end else begin
        want = predicted_results.pop_front();
        if (result.interpolated !== want.interpolated ||
            result.position_error !== want.position_error)
          note_mismatch("result mismatch", want, result);
      end
    end
  end

  // Full-scale samples of both signs at phases 0, 255 and 128.
  task automatic test_full_scale();
    for (int s = 0; s < 4; s++) send_item(write_item(5'(s), 16'sh7FFF));
    send_item(interp_item(counter_at(5'd0, 8'd0)));
    send_item(interp_item(counter_at(5'd0, 8'd255)));
    for (int s = 0; s < 4; s++) send_item(write_item(5'(s), 16'sh8000));
    send_item(interp_item(counter_at(5'd0, 8'd0)));
    send_item(interp_item(counter_at(5'd0, 8'd128)));
  endtask

  // The last legal window, with a write to the slot past the store that must change nothing.
  task automatic test_last_window_and_ignored_slot();
    send_item(write_item(5'd27, 16'sh7FFF));
    send_item(write_item(5'd28, 16'sh8000));
    send_item(write_item(5'd29, 16'sh7FFF));
    send_item(write_item(5'd30, 16'sh8000));
    send_item(write_item(5'd31, 16'sh1234));
    send_item(interp_item(counter_at(5'd27, 8'd255)));
    send_item(interp_item(counter_at(5'd27, 8'd0)));
  endtask

  task automatic test_position_overflow();
    send_item(interp_item(counter_at(5'd28, 8'd0)));
    send_item(interp_item(17'h1FFFF));
  endtask

  // A request right behind a write must already see the new sample.
  task automatic test_write_then_read();
    send_idle_pct = 0;
    send_item(write_item(5'd30, -16'sd1));
    send_item(interp_item(counter_at(5'd27, 8'd100)));
    send_item(write_item(5'd27, 16'sd1));
    send_item(interp_item(counter_at(5'd27, 8'd7)));
    send_idle_pct = 33;
  endtask

  // One decoded block followed by a run of requests at a random pitch, with stray writes and random requests mixed in.
  task automatic stream_block(input bit complete);
    logic [16:0] ctr;
    int          step;
    int          n_reads;
    for (int s = 0; s < STORE_DEPTH; s++) begin
      if (complete || $urandom_range(99) >= 15)
        send_item(write_item(5'(s), random_sample()));
      if ($urandom_range(99) < 4)
        send_item(write_item(5'd31, random_sample()));
    end
    ctr     = 17'($urandom_range(0, 'h3FFF));
    step    = $urandom_range(1, 'h3FFF);
    n_reads = $urandom_range(8, 30);
    repeat (n_reads) begin
      if ($urandom_range(99) < 8) begin
        send_item(write_item(5'($urandom_range(0, 31)), random_sample()));
      end else if ($urandom_range(99) < 5) begin
        send_item(interp_item(17'($urandom)));
      end else begin
        send_item(interp_item(ctr));
        ctr = ctr + 17'(step);
      end
    end
  endtask

  task automatic test_streaming_with_idling();
    // The first block writes every slot, so no later request reads an unwritten one.
    for (int b = 0; b < 8; b++) begin
      if (b % 3 == 2) wait_results_drained();
      stream_block(b == 0);
    end
  endtask

  task automatic test_streaming_back_to_back();
    send_idle_pct  = 0;
    sink_stall_pct = 0;
    repeat (2) stream_block(1'b0);
    send_idle_pct  = 33;
    sink_stall_pct = 33;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_full_scale();
    test_last_window_and_ignored_slot();
    test_position_overflow();
    test_write_then_read();
    test_streaming_with_idling();
    test_streaming_back_to_back();
    wait_results_drained();
    repeat (10) @(posedge clk);
    if (predicted_results.size() != 0)
      $display("%0d predicted results never arrived", predicted_results.size());
    if (mismatch_count == 0 && predicted_results.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

/* filelist.f */
hdl/gfti_pkg.sv
hdl/gfti_sample_store.sv
hdl/gaussian_four_tap_interpolator.sv
hdl/gfti_checker.sv
sim/gaussian_four_tap_interpolator_test.sv
